FILE: hw/rtl/agd_pkg.sv
// ----------------------------------------------------------------------------
// agd_pkg: shared types and constants for the ADC to LED gradient duty map
// Field widths, register indexes and the payload and pipeline stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package agd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DUTY_BITS   = 16;
    // product of a sample-wide value and a duty, also the divider remainder
    localparam int REM_BITS    = SAMPLE_BITS + DUTY_BITS;
    localparam int ADDR_BITS   = 4;

    localparam logic [1:0] REG_SAFE_LIMIT      = 2'd0;
    localparam logic [1:0] REG_EMERGENCY_LIMIT = 2'd1;
    localparam logic [1:0] REG_FULL_DUTY       = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   latched;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] red_level;
        logic [DUTY_BITS-1:0] green_level;
        logic                 blink_red;
    } t_out_item;

    typedef struct packed {
        logic                   blink;
        logic                   div_red;    // quotient replaces red
        logic                   div_green;  // quotient replaces green
        logic [DUTY_BITS-1:0]   red;
        logic [DUTY_BITS-1:0]   green;
        logic [SAMPLE_BITS-1:0] span;
        logic [REM_BITS-1:0]    rem;
        logic [DUTY_BITS-1:0]   quo;
    } t_stage;

endpackage

`default_nettype wire

FILE: hw/rtl/agd_div_pipe.sv
// ----------------------------------------------------------------------------
// agd_div_pipe: pipelined restoring divider, one quotient bit per stage
// Divides rem by span over DUTY_BITS register stages; stalled stages hold,
// empty stages fill while later ones wait.
// ----------------------------------------------------------------------------
`default_nettype none

module agd_div_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire agd_pkg::t_stage i_data,
    output logic                o_stall,
    output logic                o_valid,
    output agd_pkg::t_stage     o_data,
    input  wire logic           i_stall
);

    localparam int NSTG = agd_pkg::DUTY_BITS;

    logic            r_vld [NSTG];
    agd_pkg::t_stage r_stg [NSTG];
    logic            load  [NSTG];
    logic            src_vld [NSTG];
    agd_pkg::t_stage src   [NSTG];
    agd_pkg::t_stage n_stg [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_step
        localparam int SH = NSTG - 1 - k;

        logic [agd_pkg::REM_BITS-1:0] trial;

        if (k == 0) begin : g_first
            assign src_vld[k] = i_valid;
            assign src[k]     = i_data;
        end else begin : g_next
            assign src_vld[k] = r_vld[k-1];
            assign src[k]     = r_stg[k-1];
        end

        if (k == NSTG - 1) begin : g_last
            assign load[k] = !r_vld[k] || !i_stall;
        end else begin : g_mid
            assign load[k] = !r_vld[k] || load[k+1];
        end

        assign trial = agd_pkg::REM_BITS'(src[k].span) << SH;

        always_comb begin
            n_stg[k] = src[k];
            if (src[k].rem >= trial) begin
                n_stg[k].rem     = src[k].rem - trial;
                n_stg[k].quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (load[k]) begin
                r_vld[k] <= src_vld[k];
            end
            if (load[k] && src_vld[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_stall = !load[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_stg[NSTG-1];

    // a finished division leaves a remainder below the divisor
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && (r_stg[NSTG-1].div_red || r_stg[NSTG-1].div_green)
        |-> r_stg[NSTG-1].rem < agd_pkg::REM_BITS'(r_stg[NSTG-1].span))
        else $error("divider remainder not below divisor");

    // a held first stage keeps its contents
    a_first_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !load[0] |=> $stable(r_stg[0]))
        else $error("stalled divider stage changed");

    // a stalled result stays valid and unchanged
    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && i_stall |=> r_vld[NSTG-1] && $stable(r_stg[NSTG-1]))
        else $error("stalled divider result changed");

endmodule

`default_nettype wire

FILE: hw/rtl/adc_to_led_gradient_duty.sv
// ----------------------------------------------------------------------------
// adc_to_led_gradient_duty: ADC sample to red/green LED PWM duty map
// Classifies the sample against the safe and emergency limits, scales the
// ramp by full_duty and divides by the zone span in a pipelined divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    agd_pkg::t_in_item
//  out       output     o_out_valid / i_out_stall  agd_pkg::t_out_item
//  cfg       input      APB write, pready tied 1   safe, emergency, full duty
//
//  One transaction per cycle while the output is not stalled; each one passes stage A,
//  stage B, the one-bit-per-stage divider and the output stage, in that order.
//  Synchronous active-low reset empties the pipeline and loads register
//  defaults. A stall at the output holds the output stage; earlier stages keep
//  filling bubbles, and o_in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_to_led_gradient_duty (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    input  wire agd_pkg::t_in_item               i_in_data,
    output logic                                 o_in_stall,
    // output channel
    output logic                                 o_out_valid,
    output agd_pkg::t_out_item                   o_out_data,
    input  wire logic                            i_out_stall,
    // configuration
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [agd_pkg::ADDR_BITS-1:0]   i_paddr,
    input  wire logic [31:0]                     i_pwdata,
    output logic [31:0]                          o_prdata,
    output logic                                 o_pready
);

    localparam int SB = agd_pkg::SAMPLE_BITS;
    localparam int DB = agd_pkg::DUTY_BITS;

    logic [SB-1:0] r_safe;
    logic [SB-1:0] r_emerg;
    logic [DB-1:0] r_full;

    logic            r_a_vld, r_b_vld, r_out_vld;
    agd_pkg::t_stage r_a, r_b, n_a, n_b;
    agd_pkg::t_out_item r_out, n_out;

    logic            a_load, b_load, out_load;
    logic            div_stall, div_vld;
    agd_pkg::t_stage div_data;
    logic [1:0]      reg_idx;

    // ---------------- configuration ----------------
    assign reg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe  <= '0;
            r_emerg <= SB'(4095);
            r_full  <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (reg_idx)
                agd_pkg::REG_SAFE_LIMIT:      r_safe  <= i_pwdata[SB-1:0];
                agd_pkg::REG_EMERGENCY_LIMIT: r_emerg <= i_pwdata[SB-1:0];
                agd_pkg::REG_FULL_DUTY:       r_full  <= i_pwdata[DB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            agd_pkg::REG_SAFE_LIMIT:      o_prdata = 32'(r_safe);
            agd_pkg::REG_EMERGENCY_LIMIT: o_prdata = 32'(r_emerg);
            agd_pkg::REG_FULL_DUTY:       o_prdata = 32'(r_full);
            default:                      o_prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_load   = !r_out_vld || !i_out_stall;
    assign b_load     = !r_b_vld || !div_stall;
    assign a_load     = !r_a_vld || b_load;
    assign o_in_stall = !a_load;

    // ---------------- stage A: zone select ----------------
    always_comb begin
        n_a           = '0;
        n_a.span      = r_safe;
        if (i_in_data.latched) begin
            n_a.blink = 1'b1;
        end else if (i_in_data.sample <= r_safe) begin
            n_a.green = r_full;
            if (r_safe == '0) begin
                n_a.red = '0;
            end else if (i_in_data.sample == r_safe) begin
                n_a.red = r_full;
            end else begin
                n_a.div_red = 1'b1;
                n_a.rem     = agd_pkg::REM_BITS'(i_in_data.sample);
            end
        end else if (i_in_data.sample >= r_emerg) begin
            n_a.red = r_full;
        end else begin
            // safe < sample < emergency: ramp down, span is nonzero
            n_a.red       = r_full;
            n_a.div_green = 1'b1;
            n_a.span      = r_emerg - r_safe;
            n_a.rem       = agd_pkg::REM_BITS'(r_emerg - i_in_data.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_load) begin
            r_a_vld <= i_in_valid;
        end
        if (a_load && i_in_valid) begin
            r_a <= n_a;
        end
    end

    // ---------------- stage B: numerator product ----------------
    always_comb begin
        n_b     = r_a;
        n_b.rem = r_a.rem[SB-1:0] * r_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_load) begin
            r_b_vld <= r_a_vld;
        end
        if (b_load && r_a_vld) begin
            r_b <= n_b;
        end
    end

    // ---------------- divider ----------------
    agd_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_data  (r_b),
        .o_stall (div_stall),
        .o_valid (div_vld),
        .o_data  (div_data),
        .i_stall (!out_load)
    );

    // ---------------- output register ----------------
    always_comb begin
        n_out.blink_red   = div_data.blink;
        n_out.red_level   = div_data.div_red   ? div_data.quo : div_data.red;
        n_out.green_level = div_data.div_green ? div_data.quo : div_data.green;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= div_vld;
        end
        if (out_load && div_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_blink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.blink_red
        |-> r_out.red_level == '0 && r_out.green_level == '0)
        else $error("blink result carries nonzero levels");

    a_one_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.blink_red
        |-> r_out.red_level == r_full || r_out.green_level == r_full)
        else $error("neither channel at full duty");

    a_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_full == '0
        |-> r_out.red_level == '0 && r_out.green_level == '0)
        else $error("nonzero level with zero full duty");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_vld && r_b_vld && div_stall)
        else $error("input stalled with an empty stage ahead");

endmodule

`default_nettype wire
